[design/flvtsp_pkg.sv]
`default_nettype none

package flvtsp_pkg;

   localparam int unsigned FILE_HDR_LEN = 9;
   localparam int unsigned PREV_LEN     = 4;
   localparam int unsigned TAG_HDR_LEN  = 11;

   localparam logic [7:0] TYPE_AUDIO = 8'd8;

   // Result queue between the parser and the response channel.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      KIND_FILE_HDR = 2'd0,
      KIND_TAG_HDR  = 2'd1,
      KIND_AUDIO    = 2'd2,
      KIND_END      = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  version;
      logic [7:0]  header_flags;
      logic [31:0] data_offset;
      logic [7:0]  tag_type;
      logic [23:0] body_size;
      logic [31:0] time_stamp;
      logic [3:0]  sound_format;
      logic [1:0]  sound_rate;
      logic        sound_bits;
      logic        sound_stereo;
      logic        end_status;
   } rsp_type;

endpackage

`default_nettype wire

[design/flvtsp_if.sv]
`default_nettype none

interface flvtsp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface flvtsp_rsp_if
   import flvtsp_pkg::*;
;
   logic        valid;
   logic        ready;
   kind_type    kind;
   logic [7:0]  version;
   logic [7:0]  header_flags;
   logic [31:0] data_offset;
   logic [7:0]  tag_type;
   logic [23:0] body_size;
   logic [31:0] time_stamp;
   logic [3:0]  sound_format;
   logic [1:0]  sound_rate;
   logic        sound_bits;
   logic        sound_stereo;
   logic        end_status;

   modport source (
      output valid, output kind, output version, output header_flags, output data_offset,
      output tag_type, output body_size, output time_stamp, output sound_format,
      output sound_rate, output sound_bits, output sound_stereo, output end_status,
      input ready
   );
   modport sink (
      input valid, input kind, input version, input header_flags, input data_offset,
      input tag_type, input body_size, input time_stamp, input sound_format,
      input sound_rate, input sound_bits, input sound_stereo, input end_status,
      output ready
   );
endinterface

`default_nettype wire

[design/flv_tag_stream_parser.sv]
`default_nettype none

// Channel   Direction  Payload                                   Handshake
// req_bus   in         data_byte, end_of_stream                  valid / ready
// rsp_bus   out        kind plus header, tag, audio, end fields  valid / ready
//
// One byte is taken per cycle while req_bus.ready is high; the parse state updates in the cycle the request is taken.
// A byte yields zero, one or two results, which go into a four-entry result queue.
// Outside reset, req_bus.ready is low only while that queue holds more than two results,
// so the response side stalling is what throttles the input. Reset is synchronous; it
// resets the phase, position and byte counters and empties the queue. The end-of-stream
// byte returns the parser to that same state after its end report is queued.

module flv_tag_stream_parser
   import flvtsp_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   flvtsp_req_if.sink    req_bus,
   flvtsp_rsp_if.source  rsp_bus
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_PREV,
      PH_TAG,
      PH_BODY
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [31:0] position_ff, position_in;
   logic [31:0] offset_ff, offset_in;
   logic [3:0]  hdr_count_ff, hdr_count_in;
   logic [3:0]  field_count_ff, field_count_in;
   logic [23:0] remaining_ff, remaining_in;
   logic [7:0]  cur_type_ff, cur_type_in;
   logic [23:0] cur_size_ff, cur_size_in;
   logic [31:0] cur_time_ff, cur_time_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  flags_ff, flags_in;

   rsp_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in, wr_ptr_next;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   logic        accept;
   logic        pop;
   logic [7:0]  b;
   logic [31:0] pos_next;
   logic [31:0] off_shift;
   logic [31:0] off_clamp;
   logic [23:0] rem_dec;
   logic        boundary;
   logic        res0_valid, res1_valid;
   rsp_type     res0, res1, first_res;
   logic [1:0]  n_push;

   assign accept    = req_bus.valid && req_bus.ready;
   assign pop       = rsp_bus.valid && rsp_bus.ready;
   assign b         = req_bus.data_byte;
   assign pos_next  = position_ff + 32'd1;
   assign off_shift = {offset_ff[23:0], b};
   assign off_clamp = (off_shift < 32'(FILE_HDR_LEN)) ? 32'(FILE_HDR_LEN) : off_shift;
   assign rem_dec   = (remaining_ff != 24'd0) ? remaining_ff - 24'd1 : 24'd0;

   always_comb begin
      phase_in       = phase_ff;
      position_in    = position_ff;
      offset_in      = offset_ff;
      hdr_count_in   = hdr_count_ff;
      field_count_in = field_count_ff;
      remaining_in   = remaining_ff;
      cur_type_in    = cur_type_ff;
      cur_size_in    = cur_size_ff;
      cur_time_in    = cur_time_ff;
      version_in     = version_ff;
      flags_in       = flags_ff;
      boundary       = 1'b0;
      res0_valid     = 1'b0;
      res1_valid     = 1'b0;
      res0           = '0;
      res1           = '0;

      if (accept) begin
         position_in = pos_next;
         unique case (phase_ff)
            PH_HEADER: begin
               if (hdr_count_ff == 4'd3) begin
                  version_in = b;
               end else if (hdr_count_ff == 4'd4) begin
                  flags_in = b;
               end else if (hdr_count_ff >= 4'd5) begin
                  offset_in = off_shift;
               end
               hdr_count_in = hdr_count_ff + 4'd1;
               if (hdr_count_ff == 4'(FILE_HDR_LEN - 1)) begin
                  // The report carries the offset as read; skipping uses the clamped one.
                  res0_valid        = 1'b1;
                  res0.kind         = KIND_FILE_HDR;
                  res0.version      = version_ff;
                  res0.header_flags = flags_ff;
                  res0.data_offset  = off_shift;
                  offset_in         = off_clamp;
                  field_count_in    = 4'd0;
                  if (pos_next >= off_clamp) begin
                     phase_in = PH_PREV;
                     boundary = 1'b1;
                  end else begin
                     phase_in = PH_SKIP;
                  end
               end
            end
            PH_SKIP: begin
               if (pos_next >= offset_ff) begin
                  phase_in       = PH_PREV;
                  field_count_in = 4'd0;
                  boundary       = 1'b1;
               end
            end
            PH_PREV: begin
               field_count_in = field_count_ff + 4'd1;
               if (field_count_ff == 4'(PREV_LEN - 1)) begin
                  phase_in       = PH_TAG;
                  field_count_in = 4'd0;
                  boundary       = 1'b1;
               end
            end
            PH_TAG: begin
               if (field_count_ff == 4'd0) begin
                  cur_type_in = b;
                  cur_size_in = 24'd0;
                  cur_time_in = 32'd0;
               end else if (field_count_ff <= 4'd3) begin
                  cur_size_in = {cur_size_ff[15:0], b};
               end else if (field_count_ff <= 4'd6) begin
                  cur_time_in = {8'd0, cur_time_ff[15:0], b};
               end else if (field_count_ff == 4'd7) begin
                  cur_time_in = {b, cur_time_ff[23:0]};
               end
               field_count_in = field_count_ff + 4'd1;
               if (field_count_ff == 4'(TAG_HDR_LEN - 1)) begin
                  res0_valid      = 1'b1;
                  res0.kind       = KIND_TAG_HDR;
                  res0.tag_type   = cur_type_in;
                  res0.body_size  = cur_size_in;
                  res0.time_stamp = cur_time_in;
                  field_count_in  = 4'd0;
                  if (cur_size_in == 24'd0) begin
                     phase_in = PH_PREV;
                     boundary = 1'b1;
                  end else begin
                     phase_in     = PH_BODY;
                     remaining_in = cur_size_in;
                  end
               end
            end
            PH_BODY: begin
               // Nothing of the body has been consumed yet exactly on its first byte.
               if (cur_type_ff == TYPE_AUDIO && remaining_ff == cur_size_ff) begin
                  res0_valid        = 1'b1;
                  res0.kind         = KIND_AUDIO;
                  res0.sound_format = b[7:4];
                  res0.sound_rate   = b[3:2];
                  res0.sound_bits   = b[1];
                  res0.sound_stereo = b[0];
               end
               remaining_in = rem_dec;
               if (rem_dec == 24'd0) begin
                  phase_in       = PH_PREV;
                  field_count_in = 4'd0;
                  boundary       = 1'b1;
               end
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase

         if (req_bus.end_of_stream) begin
            res1_valid      = 1'b1;
            res1.kind       = KIND_END;
            res1.end_status = !boundary;
            phase_in        = PH_HEADER;
            position_in     = 32'd0;
            hdr_count_in    = 4'd0;
            field_count_in  = 4'd0;
         end
      end
   end

   // Results enter the queue in order: the parse result first, then the end report.
   assign first_res   = res0_valid ? res0 : res1;
   assign n_push      = {1'b0, res0_valid} + {1'b0, res1_valid};
   assign wr_ptr_next = wr_ptr_ff + QPTR_W'(1);
   assign wr_ptr_in   = wr_ptr_ff + QPTR_W'(n_push);
   assign rd_ptr_in   = rd_ptr_ff + QPTR_W'(pop);
   assign count_in    = count_ff + QCNT_W'(n_push) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HEADER;
         position_ff    <= 32'd0;
         hdr_count_ff   <= 4'd0;
         field_count_ff <= 4'd0;
         wr_ptr_ff      <= '0;
         rd_ptr_ff      <= '0;
         count_ff       <= '0;
      end else begin
         phase_ff       <= phase_in;
         position_ff    <= position_in;
         hdr_count_ff   <= hdr_count_in;
         field_count_ff <= field_count_in;
         wr_ptr_ff      <= wr_ptr_in;
         rd_ptr_ff      <= rd_ptr_in;
         count_ff       <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      offset_ff    <= offset_in;
      remaining_ff <= remaining_in;
      cur_type_ff  <= cur_type_in;
      cur_size_ff  <= cur_size_in;
      cur_time_ff  <= cur_time_in;
      version_ff   <= version_in;
      flags_ff     <= flags_in;
      if (n_push != 2'd0) begin
         queue_ff[wr_ptr_ff] <= first_res;
      end
      if (n_push == 2'd2) begin
         queue_ff[wr_ptr_next] <= res1;
      end
   end

   assign req_bus.ready        = !reset && (count_ff <= QCNT_W'(QUEUE_DEPTH - 2));
   assign rsp_bus.valid        = (count_ff != '0);
   assign rsp_bus.kind         = queue_ff[rd_ptr_ff].kind;
   assign rsp_bus.version      = queue_ff[rd_ptr_ff].version;
   assign rsp_bus.header_flags = queue_ff[rd_ptr_ff].header_flags;
   assign rsp_bus.data_offset  = queue_ff[rd_ptr_ff].data_offset;
   assign rsp_bus.tag_type     = queue_ff[rd_ptr_ff].tag_type;
   assign rsp_bus.body_size    = queue_ff[rd_ptr_ff].body_size;
   assign rsp_bus.time_stamp   = queue_ff[rd_ptr_ff].time_stamp;
   assign rsp_bus.sound_format = queue_ff[rd_ptr_ff].sound_format;
   assign rsp_bus.sound_rate   = queue_ff[rd_ptr_ff].sound_rate;
   assign rsp_bus.sound_bits   = queue_ff[rd_ptr_ff].sound_bits;
   assign rsp_bus.sound_stereo = queue_ff[rd_ptr_ff].sound_stereo;
   assign rsp_bus.end_status   = queue_ff[rd_ptr_ff].end_status;

endmodule

`default_nettype wire
